/* rtl/shte_pkg.sv */
package shte_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CFG_W       = 11;
  localparam int SZ_W        = (IDX_W + 1 > CFG_W) ? IDX_W + 1 : CFG_W;
  localparam int POS_W       = 10;
  localparam int DIV_STEPS   = 32;
  localparam int CNT_W       = $clog2(DIV_STEPS + 1);
  localparam int KEY_COUNT   = 768;
  localparam int KEY_IDX_W   = $clog2(KEY_COUNT);

  localparam logic [31:0] SEED1_INIT = 32'h7FED7FED;
  localparam logic [31:0] SEED2_INIT = 32'hEEEEEEEE;
  localparam logic [31:0] KEY_START  = 32'h00100001;
  localparam logic [31:0] KEY_MOD    = 32'h002AAAAB;
  localparam logic [31:0] KEY_MUL    = 32'd125;
  localparam logic [31:0] KEY_COLS   = 32'h100;

  typedef enum logic [1:0] {
    MODE_FIND   = 2'd0,
    MODE_INSERT = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_NOP    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    STS_OK       = 3'd0,
    STS_NOTFOUND = 3'd1,
    STS_FULL     = 3'd2,
    STS_NOTINIT  = 3'd3,
    STS_CLEARED  = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ST_CLR,
    ST_IDLE,
    ST_DIV,
    ST_PRB_RD,
    ST_PRB_CHK,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] char_code;
    logic       last_char;
    logic       no_char;
  } in_item_t;

  typedef struct packed {
    logic [2:0]       status;
    logic [POS_W-1:0] position;
  } out_item_t;

  typedef struct packed {
    logic [31:0] s0;
    logic [31:0] s1;
  } seed_t;

  typedef struct packed {
    logic        used;
    logic [31:0] ca;
    logic [31:0] cb;
  } slot_t;

  typedef struct packed {
    logic    hash_en;
    logic    seed_rst;
    logic    start_div;
    logic    div_step;
    logic    ptr_load;
    logic    rd_en;
    logic    ptr_adv;
    logic    wr_ins;
    logic    clr_step;
    logic    out_load;
    status_t out_status;
    logic    pos_ok;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic slot_used;
    logic match;
    logic wrap;
    logic clr_done;
    logic out_busy;
    logic ts_zero;
  } sts_t;

  typedef logic [31:0] key_tab_t [KEY_COUNT];

  function automatic key_tab_t gen_keys();
    key_tab_t    k;
    logic [31:0] s;
    logic [31:0] hi;
    logic [31:0] lo;
    s = KEY_START;
    for (int col = 0; col < 256; col++) begin
      for (int row = 0; row < 5; row++) begin
        s  = (s * KEY_MUL + 32'd3) % KEY_MOD;
        hi = {s[15:0], 16'h0000};
        s  = (s * KEY_MUL + 32'd3) % KEY_MOD;
        lo = {16'h0000, s[15:0]};
        if (row < 3) begin
          k[row * KEY_COLS + col] = hi | lo;
        end
      end
    end
    return k;
  endfunction

  localparam key_tab_t KEY_TAB = gen_keys();

  function automatic seed_t mix(seed_t sd, logic [31:0] key, logic [7:0] ch);
    seed_t r;
    r.s0 = key ^ (sd.s0 + sd.s1);
    r.s1 = {24'h000000, ch} + r.s0 + sd.s1 + (sd.s1 << 5) + 32'd3;
    return r;
  endfunction

endpackage

/* rtl/shte_dp.sv */
module shte_dp (
  input  logic                    clk,
  input  logic                    rst_n,
  input  shte_pkg::cmd_t          cmd,
  output shte_pkg::sts_t          sts,
  input  shte_pkg::in_item_t      in_data,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [shte_pkg::CFG_W-1:0] cfg_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output shte_pkg::out_item_t     out_data
);

  localparam int IDX_W = shte_pkg::IDX_W;
  localparam int SZ_W  = shte_pkg::SZ_W;

  logic [shte_pkg::CFG_W-1:0] table_size_r;
  logic [SZ_W-1:0]            ts;

  shte_pkg::seed_t ofs_r, ofs_nxt, ofs_post;
  shte_pkg::seed_t ca_r, ca_nxt, ca_post;
  shte_pkg::seed_t cb_r, cb_nxt, cb_post;
  shte_pkg::seed_t seed_init;
  logic [7:0]      uc;
  logic            byte_ok;

  logic [31:0]                 ha_r, hb_r;
  logic [31:0]                 div_q_r;
  logic [SZ_W-1:0]             rem_r;
  logic [shte_pkg::CNT_W-1:0]  cnt_r;
  logic [SZ_W:0]               trial;

  logic [IDX_W-1:0] ptr_r, start_r, clr_cnt_r;
  logic [IDX_W-1:0] ptr_next;
  logic [SZ_W-1:0]  ptr_inc;

  shte_pkg::slot_t mem [shte_pkg::TABLE_DEPTH];
  shte_pkg::slot_t rdata_r;
  shte_pkg::slot_t mem_wd;
  logic [IDX_W-1:0] mem_wa;
  logic             mem_we;

  logic                out_valid_r;
  shte_pkg::out_item_t out_data_r;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= '0;
    end else if (cfg_valid) begin
      table_size_r <= cfg_data;
    end
  end

  always_comb begin
    if (SZ_W'(table_size_r) > SZ_W'(shte_pkg::TABLE_DEPTH)) begin
      ts = SZ_W'(shte_pkg::TABLE_DEPTH);
    end else begin
      ts = SZ_W'(table_size_r);
    end
  end

  // hashing
  always_comb begin
    seed_init.s0 = shte_pkg::SEED1_INIT;
    seed_init.s1 = shte_pkg::SEED2_INIT;
    uc = in_data.char_code;
    if (uc >= 8'h61 && uc <= 8'h7A) begin
      uc = uc - 8'h20;
    end
    byte_ok = !in_data.no_char && (in_data.char_code != 8'h00);
    ofs_post = ofs_r;
    ca_post  = ca_r;
    cb_post  = cb_r;
    if (cmd.hash_en && byte_ok) begin
      ofs_post = shte_pkg::mix(ofs_r, shte_pkg::KEY_TAB[{2'd0, uc}], uc);
      ca_post  = shte_pkg::mix(ca_r, shte_pkg::KEY_TAB[{2'd1, uc}], uc);
      cb_post  = shte_pkg::mix(cb_r, shte_pkg::KEY_TAB[{2'd2, uc}], uc);
    end
    ofs_nxt = cmd.seed_rst ? seed_init : ofs_post;
    ca_nxt  = cmd.seed_rst ? seed_init : ca_post;
    cb_nxt  = cmd.seed_rst ? seed_init : cb_post;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ofs_r <= seed_init;
      ca_r  <= seed_init;
      cb_r  <= seed_init;
    end else begin
      ofs_r <= ofs_nxt;
      ca_r  <= ca_nxt;
      cb_r  <= cb_nxt;
    end
  end

  // remainder unit, one quotient bit per cycle
  assign trial = {rem_r, div_q_r[31]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.start_div) begin
      cnt_r <= shte_pkg::CNT_W'(shte_pkg::DIV_STEPS);
    end else if (cmd.div_step) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_div) begin
      div_q_r <= ofs_post.s0;
      ha_r    <= ca_post.s0;
      hb_r    <= cb_post.s0;
      rem_r   <= '0;
    end else if (cmd.div_step) begin
      div_q_r <= {div_q_r[30:0], 1'b0};
      if (trial >= {1'b0, ts}) begin
        rem_r <= SZ_W'(trial - {1'b0, ts});
      end else begin
        rem_r <= SZ_W'(trial);
      end
    end
  end

  // probe pointer
  assign ptr_inc  = SZ_W'(ptr_r) + 1'b1;
  assign ptr_next = (ptr_inc == ts) ? '0 : ptr_inc[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.ptr_load) begin
      ptr_r   <= rem_r[IDX_W-1:0];
      start_r <= rem_r[IDX_W-1:0];
    end else if (cmd.ptr_adv) begin
      ptr_r <= ptr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt_r <= (clr_cnt_r == IDX_W'(shte_pkg::TABLE_DEPTH - 1)) ? '0 : clr_cnt_r + 1'b1;
    end
  end

  // slot memory
  always_comb begin
    mem_we = cmd.clr_step || cmd.wr_ins;
    mem_wa = cmd.clr_step ? clr_cnt_r : ptr_r;
    mem_wd = '0;
    if (!cmd.clr_step) begin
      mem_wd.used = 1'b1;
      mem_wd.ca   = ha_r;
      mem_wd.cb   = hb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[ptr_r];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r.status   <= cmd.out_status;
      out_data_r.position <= cmd.pos_ok ? shte_pkg::POS_W'(ptr_r) : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    sts.div_done  = (cnt_r == '0);
    sts.slot_used = rdata_r.used;
    sts.match     = (rdata_r.ca == ha_r) && (rdata_r.cb == hb_r);
    sts.wrap      = (ptr_next == start_r);
    sts.clr_done  = (clr_cnt_r == IDX_W'(shte_pkg::TABLE_DEPTH - 1));
    sts.out_busy  = out_valid_r && out_stall;
    sts.ts_zero   = (ts == '0);
  end

endmodule

/* rtl/shte_ctrl.sv */
module shte_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  shte_pkg::in_item_t in_data,
  input  shte_pkg::sts_t     sts,
  output shte_pkg::cmd_t     cmd
);

  shte_pkg::state_t  state_r, state_nxt;
  shte_pkg::status_t status_r, status_nxt;
  logic              pos_ok_r, pos_ok_nxt;
  logic              ins_r, ins_nxt;
  logic              clr_resp_r, clr_resp_nxt;
  logic              accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= shte_pkg::ST_CLR;
      status_r   <= shte_pkg::STS_OK;
      pos_ok_r   <= 1'b0;
      ins_r      <= 1'b0;
      clr_resp_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      status_r   <= status_nxt;
      pos_ok_r   <= pos_ok_nxt;
      ins_r      <= ins_nxt;
      clr_resp_r <= clr_resp_nxt;
    end
  end

  assign in_stall = (state_r != shte_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt    = state_r;
    status_nxt   = status_r;
    pos_ok_nxt   = pos_ok_r;
    ins_nxt      = ins_r;
    clr_resp_nxt = clr_resp_r;
    cmd          = '0;
    cmd.out_status = status_r;
    cmd.pos_ok     = pos_ok_r;
    case (state_r)
      shte_pkg::ST_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) begin
          state_nxt = clr_resp_r ? shte_pkg::ST_RESP : shte_pkg::ST_IDLE;
        end
      end
      shte_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_data.mode == shte_pkg::MODE_CLEAR) begin
            cmd.seed_rst = 1'b1;
            pos_ok_nxt   = 1'b0;
            if (sts.ts_zero) begin
              status_nxt = shte_pkg::STS_NOTINIT;
              state_nxt  = shte_pkg::ST_RESP;
            end else begin
              status_nxt   = shte_pkg::STS_CLEARED;
              clr_resp_nxt = 1'b1;
              state_nxt    = shte_pkg::ST_CLR;
            end
          end else if (in_data.mode != shte_pkg::MODE_NOP) begin
            cmd.hash_en = 1'b1;
            if (in_data.last_char) begin
              cmd.seed_rst = 1'b1;
              pos_ok_nxt   = 1'b0;
              ins_nxt      = (in_data.mode == shte_pkg::MODE_INSERT);
              if (sts.ts_zero) begin
                status_nxt = shte_pkg::STS_NOTINIT;
                state_nxt  = shte_pkg::ST_RESP;
              end else begin
                cmd.start_div = 1'b1;
                state_nxt     = shte_pkg::ST_DIV;
              end
            end
          end
        end
      end
      shte_pkg::ST_DIV: begin
        if (sts.div_done) begin
          cmd.ptr_load = 1'b1;
          state_nxt    = shte_pkg::ST_PRB_RD;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      shte_pkg::ST_PRB_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = shte_pkg::ST_PRB_CHK;
      end
      shte_pkg::ST_PRB_CHK: begin
        state_nxt = shte_pkg::ST_RESP;
        if (ins_r) begin
          if (!sts.slot_used) begin
            cmd.wr_ins = 1'b1;
            status_nxt = shte_pkg::STS_OK;
            pos_ok_nxt = 1'b1;
          end else if (sts.wrap) begin
            status_nxt = shte_pkg::STS_FULL;
          end else begin
            cmd.ptr_adv = 1'b1;
            state_nxt   = shte_pkg::ST_PRB_RD;
          end
        end else begin
          if (!sts.slot_used) begin
            status_nxt = shte_pkg::STS_NOTFOUND;
          end else if (sts.match) begin
            status_nxt = shte_pkg::STS_OK;
            pos_ok_nxt = 1'b1;
          end else if (sts.wrap) begin
            status_nxt = shte_pkg::STS_NOTFOUND;
          end else begin
            cmd.ptr_adv = 1'b1;
            state_nxt   = shte_pkg::ST_PRB_RD;
          end
        end
      end
      shte_pkg::ST_RESP: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          clr_resp_nxt = 1'b0;
          state_nxt    = shte_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = shte_pkg::ST_IDLE;
      end
    endcase
  end

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !sts.out_busy)
    else $error("result loaded over an untaken transfer");

  a_resp_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == shte_pkg::ST_RESP && sts.out_busy) |=> state_r == shte_pkg::ST_RESP)
    else $error("response dropped while output stalled");

  a_ins_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_ins |-> !sts.slot_used)
    else $error("insert overwrites a used slot");

endmodule

/* rtl/string_hash_table_engine.sv */
// String hash table engine. A string arrives one byte per input transfer and each byte is
// hashed into the hash registers as it is taken, so non-final bytes are taken back to back.
// The transfer that carries last_char then starts a bit-serial reduction of the offset hash
// by table_size, followed by slot probes (each one memory read, then one check) and a load
// of the result register; a result can wait there while the next string streams in.
// A clear transfer with a nonzero table_size sweeps the whole slot memory one slot a cycle.
// After reset the same clearing pass runs before the first input transfer is taken;
// configuration writes are accepted at any time.
module string_hash_table_engine (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  shte_pkg::in_item_t         in_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output shte_pkg::out_item_t        out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [shte_pkg::CFG_W-1:0] cfg_data
);

  shte_pkg::cmd_t cmd;
  shte_pkg::sts_t sts;

  shte_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .sts      (sts),
    .cmd      (cmd)
  );

  shte_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
